// ===== src/base64_stream_encoder_unit_assert.svh =====
// Assertion macros for the base64 stream encoder, removed when SYNTH is defined.
`ifndef BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define B64_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("base64 encoder assertion failed");
// Expression must never be true outside reset.
`define B64_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("base64 encoder forbidden condition seen");
`else
`define B64_ASSERT(label, clk, rst, prop)
`define B64_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== src/b64enc_pkg.sv =====
// Shared types, constants and the character table of the base64 stream encoder.
package b64enc_pkg;

   localparam int unsigned LIMIT_W     = 16;
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;
   localparam logic [LEN_W-1:0]   LEN_MAX     = 16'hFFFF;

   // Bytes held in a group, and the character slot that ends a group.
   localparam logic [1:0] GROUP_ONE   = 2'd1;
   localparam logic [1:0] GROUP_TWO   = 2'd2;
   localparam logic [1:0] GROUP_FULL  = 2'd3;
   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;
   localparam logic [1:0] SLOT_LAST   = 2'd3;
   localparam logic [2:0] CHARS_PER_GROUP = 3'd4;

   localparam logic [6:0] PAD_CODE = 7'd64;

   // One unit of work handed from the front end to the back end.
   typedef struct packed {
      logic              emit;      // four characters follow; else a bare end word
      logic [1:0]        total;     // source bytes in the group
      logic [23:0]       group;     // first byte in bits 23..16
      logic              last;      // message ends with this job
      logic              truncated;
      logic [LEN_W-1:0]  enc_len;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // Base64 alphabet; code 64 gives the padding character.
   function automatic logic [7:0] b64_char(input logic [6:0] code);
      logic [7:0] code_ext;
      logic [7:0] ch;
      code_ext = {1'b0, code};
      if (code < 7'd26) begin
         ch = code_ext + 8'h41;
      end else if (code < 7'd52) begin
         ch = code_ext + 8'd71;
      end else if (code < 7'd62) begin
         ch = code_ext - 8'd4;
      end else if (code == 7'd62) begin
         ch = 8'h2B;
      end else if (code == 7'd63) begin
         ch = 8'h2F;
      end else begin
         ch = 8'h3D;
      end
      return ch;
   endfunction

endpackage

// ===== src/b64enc_req_if.sv =====
// Source byte channel of the base64 stream encoder.
interface b64enc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/b64enc_rsp_if.sv =====
// Character result channel of the base64 stream encoder.
interface b64enc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_char;
   logic        char_valid;
   logic        last_char;
   logic        truncated;
   logic [15:0] encoded_length;

   modport source (output valid, output out_char, output char_valid, output last_char,
                   output truncated, output encoded_length, input ready);
   modport sink   (input valid, input out_char, input char_valid, input last_char,
                   input truncated, input encoded_length, output ready);
endinterface

// ===== src/b64enc_queue.sv =====
// Two-entry job queue between the encoder front end and back end.
module b64enc_queue
   import b64enc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          pop_job,
   output queue_status_type status
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_END = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   job_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_END) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_END) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job          = entries_ff[rd_ptr_ff];
   assign status.full      = (count_ff == CNT_FULL);
   assign status.not_empty = (count_ff != '0);

endmodule

// ===== src/b64enc_front.sv =====
// Front end: takes source bytes, builds 3-byte groups, applies the limit, queues jobs.
module b64enc_front
   import b64enc_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
)
(
   input  logic                clock,
   input  logic                reset,
   b64enc_req_if.sink          req_bus,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data,
   input  queue_status_type    q_status,
   output logic                q_push,
   output job_type             q_job
);

   logic [LIMIT_W-1:0]     limit_ff;
   logic                   stopped_ff, stopped_in;
   logic [15:0]            pend_ff, pend_in;
   logic [1:0]             pcnt_ff, pcnt_in;
   logic [LIMIT_W-1:0]     chars_ff, chars_in;
   logic [COUNT_WIDTH-1:0] bytes_ff, bytes_in;
   logic [1:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] groups_ff, groups_in;

   logic                   accept;
   logic                   bytes_inc;
   logic [1:0]             total;
   logic [23:0]            aligned;
   logic                   closes;
   logic                   fits;
   logic                   emit;
   logic                   stopped_new;
   logic [COUNT_WIDTH+17:0] len_wide;
   logic [LEN_W-1:0]       enc_len;

   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      // Byte count saturates; the group count tracks ceil(bytes/3) alongside it.
      bytes_inc = !(&bytes_ff);
      bytes_in  = bytes_inc ? bytes_ff + 1'b1 : bytes_ff;
      phase_in  = phase_ff;
      groups_in = groups_ff;
      if (bytes_inc) begin
         phase_in = (phase_ff == GROUP_TWO) ? 2'd0 : phase_ff + 1'b1;
         if (phase_ff == 2'd0) begin
            groups_in = groups_ff + 1'b1;
         end
      end
      len_wide = {16'd0, groups_in, 2'b00};
      enc_len  = (|len_wide[COUNT_WIDTH+17:LEN_W]) ? LEN_MAX : len_wide[LEN_W-1:0];

      total = pcnt_ff + 1'b1;
      unique case (total)
         GROUP_ONE:  aligned = {req_bus.data_byte, 16'd0};
         GROUP_TWO:  aligned = {pend_ff[7:0], req_bus.data_byte, 8'd0};
         default:    aligned = {pend_ff, req_bus.data_byte};
      endcase

      closes      = !stopped_ff && ((total == GROUP_FULL) || req_bus.last_byte);
      fits        = ({1'b0, chars_ff} + 17'(CHARS_PER_GROUP)) <= {1'b0, limit_ff};
      emit        = closes && fits;
      stopped_new = stopped_ff || (closes && !fits);

      stopped_in = stopped_new;
      pend_in    = pend_ff;
      pcnt_in    = pcnt_ff;
      chars_in   = chars_ff;
      if (closes) begin
         pend_in = '0;
         pcnt_in = '0;
         if (emit) begin
            chars_in = chars_ff + LIMIT_W'(CHARS_PER_GROUP);
         end
      end else if (!stopped_ff) begin
         pend_in = aligned[23:8] >> 0;
         pend_in = {pend_ff[7:0], req_bus.data_byte};
         pcnt_in = total;
      end
      if (req_bus.last_byte) begin
         stopped_in = 1'b0;
         pend_in    = '0;
         pcnt_in    = '0;
         chars_in   = '0;
         bytes_in   = '0;
         phase_in   = '0;
         groups_in  = '0;
      end
   end

   assign q_push          = accept && (emit || req_bus.last_byte);
   assign q_job.emit      = emit;
   assign q_job.total     = total;
   assign q_job.group     = aligned;
   assign q_job.last      = req_bus.last_byte;
   assign q_job.truncated = req_bus.last_byte && stopped_new;
   assign q_job.enc_len   = req_bus.last_byte ? enc_len : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_RESET;
         stopped_ff <= 1'b0;
         pend_ff    <= '0;
         pcnt_ff    <= '0;
         chars_ff   <= '0;
         bytes_ff   <= '0;
         phase_ff   <= '0;
         groups_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (accept) begin
            stopped_ff <= stopped_in;
            pend_ff    <= pend_in;
            pcnt_ff    <= pcnt_in;
            chars_ff   <= chars_in;
            bytes_ff   <= bytes_in;
            phase_ff   <= phase_in;
            groups_ff  <= groups_in;
         end
      end
   end

endmodule

// ===== src/b64enc_back.sv =====
// Back end: takes one job at a time and sends its characters, one word per cycle while rsp_bus.ready is high.
module b64enc_back
   import b64enc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          q_job,
   output logic             q_pop,
   b64enc_rsp_if.source     rsp_bus
);

   logic        busy_ff, busy_in;
   job_type     job_ff;
   logic [1:0]  slot_ff, slot_in;

   logic        is_final;
   logic        done;
   logic [6:0]  code;

   assign is_final = !job_ff.emit || (slot_ff == SLOT_LAST);
   assign done     = busy_ff && rsp_bus.ready && is_final;
   assign q_pop    = q_status.not_empty && (!busy_ff || done);

   always_comb begin
      unique case (slot_ff)
         SLOT_FIRST:  code = {1'b0, job_ff.group[23:18]};
         SLOT_SECOND: code = {1'b0, job_ff.group[17:12]};
         SLOT_THIRD:  code = (job_ff.total != GROUP_ONE) ? {1'b0, job_ff.group[11:6]}
                                                         : PAD_CODE;
         default:     code = (job_ff.total == GROUP_FULL) ? {1'b0, job_ff.group[5:0]}
                                                          : PAD_CODE;
      endcase

      busy_in = busy_ff;
      slot_in = slot_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         slot_in = SLOT_FIRST;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_bus.ready) begin
         slot_in = slot_ff + 1'b1;
      end
   end

   assign rsp_bus.valid          = busy_ff;
   assign rsp_bus.char_valid     = job_ff.emit;
   assign rsp_bus.out_char       = job_ff.emit ? b64_char(code) : 8'd0;
   assign rsp_bus.last_char      = job_ff.last && is_final;
   assign rsp_bus.truncated      = job_ff.last && is_final && job_ff.truncated;
   assign rsp_bus.encoded_length = (job_ff.last && is_final) ? job_ff.enc_len : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_job;
      end
   end

endmodule

// ===== src/base64_stream_encoder_unit.sv =====
// Top level of the base64 stream encoder: front end, job queue and character back end.
//
//   channel   direction  handshake          word
//   req_bus   in         valid / ready      data_byte, last_byte
//   rsp_bus   out        valid / ready      out_char, char_valid, last_char,
//                                           truncated, encoded_length
//   csr_*     in         csr_wr_en only     csr_wr_data = out_limit
//
// The front end takes one source byte per cycle while the two-entry job queue has room.
// The back end sends one character word per cycle while rsp_bus.ready is high, and a
// full 3-byte group gives four character words at the result port. A group's first
// character is valid once its job has passed the job queue and the back end's job_ff.
// Reset is synchronous and clears all message state; out_limit returns to 65535.
// A stall on the result side fills the queue and then drops req_bus.ready.
`include "base64_stream_encoder_unit_assert.svh"

module base64_stream_encoder_unit
   import b64enc_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
)
(
   input  logic                clock,
   input  logic                reset,
   b64enc_req_if.sink          req_bus,
   b64enc_rsp_if.source        rsp_bus,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data
);

   // Jobs: either one finished group (four characters, padded as needed) or a
   // bare end word when the message closes with nothing left to send.
   logic             q_push;
   logic             q_pop;
   job_type          push_job;
   job_type          pop_job;
   queue_status_type q_status;

   b64enc_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   b64enc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   b64enc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_job    (pop_job),
      .q_pop    (q_pop),
      .rsp_bus  (rsp_bus)
   );

   // The front end never writes into a full queue, and the back end never reads an empty one.
   `B64_ASSERT_NEVER(a_no_push_full, clock, reset, q_push && q_status.full)
   `B64_ASSERT_NEVER(a_no_pop_empty, clock, reset, q_pop && !q_status.not_empty)
   // A word without a character is only ever the closing word of a message.
   `B64_ASSERT(a_bare_is_last, clock, reset,
      (rsp_bus.valid && !rsp_bus.char_valid) |-> rsp_bus.last_char)
   // Status fields stay zero on every word but the closing one.
   `B64_ASSERT(a_status_on_last, clock, reset,
      (rsp_bus.valid && !rsp_bus.last_char) |->
         (!rsp_bus.truncated && rsp_bus.encoded_length == '0))

endmodule

// ===== tb/tb_base64_stream_encoder_unit.sv =====
// Self-checking testbench for base64_stream_encoder_unit with a predicting scoreboard.
`timescale 1ns / 100ps

module tb_base64_stream_encoder_unit;
   import b64enc_pkg::*;

   // One character word as it leaves the result port.
   typedef struct packed {
      logic [7:0]  ch;
      logic        valid;
      logic        last;
      logic        trunc;
      logic [15:0] len;
   } char_word_type;

   // The scoreboard keeps its own copy of the encoder state. Each accepted source byte
   // is run through the encoding rules and the character words it causes are queued.
   // Each word taken from the result port is checked against the oldest queued word.
   class char_scoreboard;
      char_word_type      expected_chars[$];
      int unsigned        mismatches;
      int unsigned        words_checked;
      logic [LIMIT_W-1:0] limit;
      logic [15:0]        held;
      logic [1:0]         held_count;
      int unsigned        chars_out;
      logic [15:0]        bytes_in;
      logic               halted;
      string              alphabet;

      function new();
         alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
         limit = LIMIT_RESET;
         mismatches = 0;
         words_checked = 0;
         clear_message();
      endfunction

      function void clear_message();
         held = '0;
         held_count = '0;
         chars_out = 0;
         bytes_in = '0;
         halted = 1'b0;
      endfunction

      function void set_limit(input logic [LIMIT_W-1:0] value);
         limit = value;
      endfunction

      function int unsigned waiting();
         return expected_chars.size();
      endfunction

      function char_word_type make_char(input logic [7:0] ch);
         char_word_type w;
         w = '0;
         w.ch = ch;
         w.valid = 1'b1;
         return w;
      endfunction

      // Works out the words that one accepted source byte causes.
      function void note_byte(input logic [7:0] data, input logic last);
         char_word_type w[4];
         int            n;
         logic [1:0]    total;
         logic [23:0]   grp;
         logic [23:0]   aligned;
         int unsigned   enc;
         n = 0;
         if (bytes_in != 16'hFFFF) begin
            bytes_in = bytes_in + 16'd1;
         end
         if (!halted) begin
            total = held_count + 2'd1;
            grp = {held, data};
            if (total == GROUP_FULL || last) begin
               // Left-justify the group so that its first byte sits in bits 23..16.
               aligned = grp << (8 * (3 - total));
               if (chars_out + 4 <= limit) begin
                  w[0] = make_char(alphabet[aligned[23:18]]);
                  w[1] = make_char(alphabet[aligned[17:12]]);
                  w[2] = make_char(alphabet[total >= GROUP_TWO ? aligned[11:6] : PAD_CODE]);
                  w[3] = make_char(alphabet[total == GROUP_FULL ? aligned[5:0] : PAD_CODE]);
                  n = 4;
                  chars_out += 4;
               end else begin
                  halted = 1'b1;
               end
               held = '0;
               held_count = '0;
            end else begin
               held = grp[15:0];
               held_count = total;
            end
         end
         if (last) begin
            enc = ((int'(bytes_in) + 2) / 3) * 4;
            if (enc > LEN_MAX) begin
               enc = LEN_MAX;
            end
            if (n == 0) begin
               w[0] = '0;
               n = 1;
            end
            w[n-1].last = 1'b1;
            w[n-1].trunc = halted;
            w[n-1].len = enc[15:0];
            clear_message();
         end
         for (int i = 0; i < n; i++) begin
            expected_chars.push_back(w[i]);
         end
      endfunction

      task report_mismatch(input string msg);
         $display("MISMATCH word %0d: %s", words_checked, msg);
         mismatches++;
      endtask

      task check_word(input char_word_type got);
         char_word_type want;
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected word char=%02h valid=%b last=%b",
                                      got.ch, got.valid, got.last));
         end else begin
            want = expected_chars.pop_front();
            if (got.ch !== want.ch)
               report_mismatch($sformatf("out_char %02h, want %02h", got.ch, want.ch));
            if (got.valid !== want.valid)
               report_mismatch($sformatf("char_valid %b, want %b", got.valid, want.valid));
            if (got.last !== want.last)
               report_mismatch($sformatf("last_char %b, want %b", got.last, want.last));
            if (got.trunc !== want.trunc)
               report_mismatch($sformatf("truncated %b, want %b", got.trunc, want.trunc));
            if (got.len !== want.len)
               report_mismatch($sformatf("encoded_length %0d, want %0d", got.len, want.len));
         end
         words_checked++;
      endtask
   endclass

   localparam int unsigned CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   b64enc_req_if req_bus ();
   b64enc_rsp_if rsp_bus ();

   char_scoreboard sb;
   int unsigned    send_idle_pct;
   int unsigned    recv_stall_pct;
   int unsigned    bytes_sent;
   int unsigned    cycle_count;

   base64_stream_encoder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 20 ns clock period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result side. The handshake is sampled with the values from before the edge, then
   // ready is redrawn for the next cycle, so stalls land on every phase of a group.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_word('{rsp_bus.out_char, rsp_bus.char_valid, rsp_bus.last_char,
                         rsp_bus.truncated, rsp_bus.encoded_length});
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("base64_stream_encoder_unit verification failed");
         $finish;
      end
   end

   // Offers one source byte, with random idle cycles in front of it, and waits for the
   // edge that takes it. Valid is left high so that back-to-back words need no gap.
   task automatic send_byte(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= data;
      req_bus.last_byte <= last;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      sb.note_byte(data, last);
      bytes_sent++;
   endtask

   // One whole message of random bytes; the final byte carries the last flag.
   task automatic send_message(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(255)), i == len - 1);
      end
   endtask

   // Random messages until about count bytes have gone in. Mostly short messages, so
   // every group size and the truncation point are hit often, with a few longer ones.
   task automatic run_messages(input int unsigned count);
      int unsigned start;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         if ($urandom_range(7) == 0) begin
            send_message($urandom_range(10, 24));
         end else begin
            send_message($urandom_range(1, 9));
         end
      end
   endtask

   // Drops valid and waits until every expected word has come back, then idles so that
   // anything still moving through the job queue can finish.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.waiting() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // The limit register is only written while the encoder is idle.
   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_limit(value);
   endtask

   initial begin
      // Every input driven here starts at a known value, with reset asserted.
      sb = new();
      send_idle_pct = 8;
      recv_stall_pct = 62;
      bytes_sent = 0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last_byte <= 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with no limit in the way: one, two and three byte groups, all
      // zero and all one bytes, and a message that ends with a byte left over.
      write_limit(LIMIT_RESET);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'h80, 1'b1);
      settle();

      // A zero limit drops the first group, so each message ends with a bare end word.
      write_limit('0);
      send_byte(8'h41, 1'b1);
      send_byte(8'h42, 1'b0);
      send_byte(8'h43, 1'b1);
      settle();

      // A limit of one group: the second group is dropped along with everything after it.
      write_limit(16'd4);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(8'h05, 1'b1);
      settle();

      // A limit that is not a multiple of four. The first message just fits; the second
      // loses its padded tail group, which checks that the state cleared in between.
      write_limit(16'd6);
      send_byte(8'h10, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h30, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hF0, 1'b1);
      settle();

      // Random part, sender mostly busy and receiver often stalled, with small limits.
      write_limit(LIMIT_W'($urandom_range(0, 30)));
      run_messages(35);
      settle();
      write_limit(LIMIT_W'($urandom_range(12, 60)));
      run_messages(35);
      settle();

      // The other way round, with no limit.
      send_idle_pct = 62;
      recv_stall_pct = 8;
      write_limit(LIMIT_RESET);
      run_messages(60);
      settle();

      // No idling on either side.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_limit(LIMIT_W'($urandom_range(4, 40)));
      run_messages(40);
      settle();

      // A few short messages with the limit lifted again after a limited run.
      write_limit(LIMIT_RESET);
      run_messages(10);
      settle();
      repeat (20) @(posedge clock);

      if (sb.mismatches == 0 && sb.waiting() == 0) begin
         $display("base64_stream_encoder_unit verification clean");
      end else begin
         $display("base64_stream_encoder_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/b64enc_pkg.sv
src/b64enc_req_if.sv
src/b64enc_rsp_if.sv
src/b64enc_queue.sv
src/b64enc_front.sv
src/b64enc_back.sv
src/base64_stream_encoder_unit.sv
tb/tb_base64_stream_encoder_unit.sv
